// ===== src/pipe_endpoint_flow_term_fsm_defines.svh =====
// Assertion helpers shared by the RTL of the pipe endpoint.
`ifndef PIPE_ENDPOINT_FLOW_TERM_FSM_DEFINES_SVH
`define PIPE_ENDPOINT_FLOW_TERM_FSM_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define PEFT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define PEFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/peft_pkg.sv =====
`default_nettype none
package peft_pkg;

  localparam int CNT_W                = 48;
  localparam int REG_W                = 16;
  localparam int READ_NOTIFY_INTERVAL = 256;
  localparam int NOTE_CNT_W           = (READ_NOTIFY_INTERVAL > 1) ?
                                        $clog2(READ_NOTIFY_INTERVAL) : 1;
  localparam logic [NOTE_CNT_W-1:0] NOTE_LAST = NOTE_CNT_W'(READ_NOTIFY_INTERVAL - 1);
  localparam logic [CNT_W-1:0]      CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [REG_W-1:0]      HWM_RESET = 16'd1000;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HWM   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST = 1'b1;

  localparam logic [2:0] PS_ACTIVE     = 3'd0;
  localparam logic [2:0] PS_DELIM_RCVD = 3'd1;
  localparam logic [2:0] PS_WAIT_DELIM = 3'd2;
  localparam logic [2:0] PS_TERM_SENT1 = 3'd3;
  localparam logic [2:0] PS_TERM_SENT2 = 3'd4;
  localparam logic [2:0] PS_TERM_ACK   = 3'd5;

  typedef enum logic [2:0] {
    OP_READ      = 3'd0,
    OP_WRITE     = 3'd1,
    OP_ACT_WRITE = 3'd2,
    OP_ACT_READ  = 3'd3,
    OP_TERMINATE = 3'd4,
    OP_PEER_TERM = 3'd5,
    OP_DELIMITER = 3'd6
  } op_t;

  typedef enum logic [5:0] {
    ST_ACTIVE     = 6'b000001,
    ST_DELIM_RCVD = 6'b000010,
    ST_WAIT_DELIM = 6'b000100,
    ST_TERM_SENT1 = 6'b001000,
    ST_TERM_SENT2 = 6'b010000,
    ST_TERM_ACK   = 6'b100000
  } term_state_t;

  // Input payload, first field in the highest bits.
  typedef struct packed {
    logic             delay_request;
    logic [CNT_W-1:0] peer_read_count;
    logic             msg_is_credential;
    logic             queue_has_msg;
  } peft_item_t;

  // Result payload, first field in the highest bits.
  typedef struct packed {
    logic             out_open;
    logic             in_open;
    logic [2:0]       pipe_state;
    logic             write_woken;
    logic             read_woken;
    logic             term_cmd;
    logic [CNT_W-1:0] read_count_out;
    logic             notify_peer_read;
    logic             credential_dropped;
    logic             accepted;
  } peft_result_t;

  function automatic logic [2:0] state_code(input term_state_t st);
    logic [2:0] code;
    unique case (st)
      ST_ACTIVE:     code = PS_ACTIVE;
      ST_DELIM_RCVD: code = PS_DELIM_RCVD;
      ST_WAIT_DELIM: code = PS_WAIT_DELIM;
      ST_TERM_SENT1: code = PS_TERM_SENT1;
      ST_TERM_SENT2: code = PS_TERM_SENT2;
      ST_TERM_ACK:   code = PS_TERM_ACK;
      default:       code = PS_ACTIVE;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

// ===== src/pipe_endpoint_flow_term_fsm.sv =====
// Control side of one end of a message pipe. Each input transaction is one event (op in
// in_tuser); the block answers it with exactly one result transaction. Events are taken at
// one per cycle: the event is decoded against the state registers in the same cycle it is
// accepted, and state and result are written together into registers, so the result is shown
// in the cycle after acceptance. The only limit on throughput is the single output register;
// a new event is taken whenever that register is empty or being drained in the same cycle.
// Outbound writes are refused once writes minus peer-reported reads reaches
// high_water_mark + hwm_boost (high_water_mark of zero means no limit). Counters saturate
// at all ones. Configuration writes must only be issued while no result is pending.
`default_nettype none
`include "pipe_endpoint_flow_term_fsm_defines.svh"
module pipe_endpoint_flow_term_fsm (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // cfg
  input  wire logic                          cfg_we,
  input  wire logic [peft_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [peft_pkg::REG_W-1:0]    cfg_wdata,
  // input stream
  input  wire logic                          in_tvalid,
  output      logic                          in_tready,
  // low to high: queue_has_msg, msg_is_credential, peer_read_count[47:0], delay_request
  input  wire logic [55:0]                   in_tdata,
  // op
  input  wire logic [2:0]                    in_tuser,
  // result stream
  output      logic                          out_tvalid,
  input  wire logic                          out_tready,
  // low to high: accepted, credential_dropped, notify_peer_read, read_count_out[47:0],
  // term_cmd, read_woken, write_woken, pipe_state[2:0], in_open, out_open
  output      logic [63:0]                   out_tdata
);
  import peft_pkg::*;

  localparam int ITEM_W = $bits(peft_item_t);
  localparam int RES_W  = $bits(peft_result_t);

  logic [REG_W-1:0]      hwm_r, boost_r;
  term_state_t           st_r, st_nxt;
  logic                  in_flag_r, in_flag_nxt;
  logic                  out_flag_r, out_flag_nxt;
  logic [CNT_W-1:0]      reads_r, reads_nxt;
  logic [CNT_W-1:0]      writes_r, writes_nxt;
  logic [CNT_W-1:0]      peer_r, peer_nxt;
  logic [NOTE_CNT_W-1:0] note_r, note_nxt;
  logic                  out_valid_r;
  peft_result_t          res_r, res_nxt;

  peft_item_t            item;
  op_t                   op;
  logic                  in_acc;
  logic                  can_read, can_read_pt;
  logic [CNT_W-1:0]      outstanding;
  logic [REG_W:0]        limit;
  logic                  limit_hit;

  assign item      = peft_item_t'(in_tdata[ITEM_W-1:0]);
  assign op        = op_t'(in_tuser);
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign can_read    = in_flag_r && (st_r == ST_ACTIVE || st_r == ST_WAIT_DELIM);
  assign outstanding = (writes_r > peer_r) ? writes_r - peer_r : '0;
  assign limit       = {1'b0, hwm_r} + {1'b0, boost_r};
  assign limit_hit   = outstanding >= CNT_W'(limit);

  always_comb begin
    st_nxt       = st_r;
    in_flag_nxt  = in_flag_r;
    out_flag_nxt = out_flag_r;
    reads_nxt    = reads_r;
    writes_nxt   = writes_r;
    peer_nxt     = peer_r;
    note_nxt     = note_r;
    res_nxt      = '0;
    can_read_pt  = 1'b0;

    case (op)
      OP_READ: begin
        if (can_read) begin
          if (!item.queue_has_msg) begin
            in_flag_nxt = 1'b0;
          end else if (item.msg_is_credential) begin
            res_nxt.credential_dropped = 1'b1;
          end else begin
            res_nxt.accepted = 1'b1;
            if (reads_r != CNT_MAX) begin
              reads_nxt = reads_r + 1'b1;
              // Tracks reads_done modulo the notify interval.
              if (note_r == NOTE_LAST) begin
                note_nxt = '0;
                res_nxt.notify_peer_read = 1'b1;
              end else begin
                note_nxt = note_r + 1'b1;
              end
            end
          end
        end
      end
      OP_WRITE: begin
        if (out_flag_r && st_r == ST_ACTIVE) begin
          if (hwm_r != '0 && limit_hit) begin
            out_flag_nxt = 1'b0;
          end else begin
            res_nxt.accepted = 1'b1;
            if (writes_r != CNT_MAX) begin
              writes_nxt = writes_r + 1'b1;
            end
          end
        end
      end
      OP_ACT_WRITE: begin
        if (item.peer_read_count > peer_r) begin
          peer_nxt = item.peer_read_count;
        end
        if (!out_flag_r && st_r == ST_ACTIVE) begin
          out_flag_nxt        = 1'b1;
          res_nxt.write_woken = 1'b1;
        end
      end
      OP_ACT_READ: begin
        if (!in_flag_r && (st_r == ST_ACTIVE || st_r == ST_WAIT_DELIM)) begin
          in_flag_nxt        = 1'b1;
          res_nxt.read_woken = 1'b1;
        end
      end
      OP_TERMINATE: begin
        if (st_r != ST_TERM_SENT1 && st_r != ST_TERM_SENT2 && st_r != ST_TERM_ACK) begin
          if (st_r == ST_ACTIVE) begin
            st_nxt = ST_TERM_SENT1;
          end else if (st_r == ST_DELIM_RCVD) begin
            st_nxt = ST_TERM_SENT2;
          end
          res_nxt.term_cmd = 1'b1;
        end
      end
      OP_PEER_TERM: begin
        if (st_r == ST_ACTIVE) begin
          st_nxt = ST_WAIT_DELIM;
        end else if (st_r == ST_TERM_SENT1) begin
          st_nxt = ST_TERM_SENT2;
        end else if (st_r == ST_TERM_SENT2 || st_r == ST_DELIM_RCVD) begin
          st_nxt = ST_TERM_ACK;
        end
        // The read check uses the state after the advance.
        can_read_pt = in_flag_r && (st_nxt == ST_ACTIVE || st_nxt == ST_WAIT_DELIM);
        if (can_read_pt && !item.queue_has_msg) begin
          in_flag_nxt = 1'b0;
        end
      end
      OP_DELIMITER: begin
        if (st_r == ST_ACTIVE) begin
          st_nxt = ST_DELIM_RCVD;
        end else if (st_r == ST_WAIT_DELIM || st_r == ST_TERM_SENT1 ||
                     st_r == ST_TERM_SENT2) begin
          st_nxt = ST_TERM_ACK;
        end
      end
      default: begin
      end
    endcase

    res_nxt.read_count_out = reads_nxt;
    res_nxt.pipe_state     = state_code(st_nxt);
    res_nxt.in_open        = in_flag_nxt;
    res_nxt.out_open       = out_flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hwm_r       <= HWM_RESET;
      boost_r     <= '0;
      st_r        <= ST_ACTIVE;
      in_flag_r   <= 1'b1;
      out_flag_r  <= 1'b1;
      reads_r     <= '0;
      writes_r    <= '0;
      peer_r      <= '0;
      note_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_HWM:   hwm_r   <= cfg_wdata;
          CFG_BOOST: boost_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        st_r       <= st_nxt;
        in_flag_r  <= in_flag_nxt;
        out_flag_r <= out_flag_nxt;
        reads_r    <= reads_nxt;
        writes_r   <= writes_nxt;
        peer_r     <= peer_nxt;
        note_r     <= note_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(64 - RES_W)'(0), res_r};

  `PEFT_ASSERT_NEXT(a_acc_gives_result, in_acc, out_valid_r, "accepted event produced no result")
  `PEFT_ASSERT_NEXT(a_reads_monotonic, 1'b1, reads_r >= $past(reads_r), "read counter went back")
  `PEFT_ASSERT_NOW(a_cred_excl, out_valid_r, !(res_r.accepted && res_r.credential_dropped),
    "credential drop reported together with an accepted read")
  `PEFT_ASSERT_NOW(a_notify_acc, out_valid_r && res_r.notify_peer_read, res_r.accepted,
    "read notification without a counted read")
  `PEFT_ASSERT_NOW(a_wwake_open, out_valid_r && res_r.write_woken,
    res_r.out_open && res_r.pipe_state == PS_ACTIVE, "write wake while outbound closed")

endmodule
`default_nettype wire
